// ===== design/bdgm_pkg.sv =====
package bdgm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DELAY_W    = 9;
    localparam int GAIN_W     = 16;

    localparam logic [GAIN_W-1:0] UNITY = 16'h8000;

    localparam logic [CFG_IDX_W-1:0] CFG_STEREO_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_GAIN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_GAIN = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL1,
        ST_RND1,
        ST_MUL2,
        ST_RND2,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic load_in;
        logic mem_step;
        logic mul1;
        logic rnd1;
        logic mul2;
        logic rnd2;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic stereo;
    } t_stat;

endpackage

// ===== design/bdgm_line.sv =====
module bdgm_line #(
    parameter int DEPTH = 512,
    parameter int W     = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic signed [W-1:0]      i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic signed [W-1:0]      o_rdata
);

    logic signed [W-1:0] r_mem [DEPTH];
    logic signed [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bdgm_lane.sv =====
module bdgm_lane #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  bdgm_pkg::t_cmd                i_cmd,
    input  logic                          i_mono,
    input  logic                          i_kill,
    input  logic signed [SAMPLE_BITS-1:0] i_dry_in,
    input  logic signed [SAMPLE_BITS-1:0] i_line,
    input  logic [bdgm_pkg::GAIN_W-1:0]   i_gain,
    input  logic [bdgm_pkg::GAIN_W-1:0]   i_dist,
    input  logic [bdgm_pkg::GAIN_W-1:0]   i_dry,
    input  logic [bdgm_pkg::GAIN_W-1:0]   i_wet,
    output logic signed [SAMPLE_BITS-1:0] o_res
);
    import bdgm_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int XW = (S > GAIN_W + 1) ? S : GAIN_W + 1;
    localparam int CW = GAIN_W + 1;
    localparam int PW = XW + CW;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(16384);
    localparam logic signed [SW-1:0] HI   = {{(SW-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [SW-1:0] LO   = {{(SW-S+1){1'b1}}, {(S-1){1'b0}}};

    logic signed [XW-1:0] xa, xb;
    logic signed [CW-1:0] ca, cb;
    logic signed [PW-1:0] r_pa, r_pb;
    logic signed [XW-1:0] r_mid;
    logic signed [S-1:0]  r_res;
    logic signed [SW-1:0] sum, rnd_v;
    logic signed [S-1:0]  sat_v;

    always_comb begin
        xa = '0;
        ca = '0;
        xb = '0;
        cb = '0;
        priority if (i_cmd.mul1 && i_mono) begin
            xa = $signed(XW'(i_dist));
            ca = $signed({1'b0, i_wet});
        end else if (i_cmd.mul1) begin
            xa = XW'(i_line);
            ca = $signed({1'b0, i_gain});
        end else if (i_cmd.mul2 && i_mono) begin
            xa = XW'(i_dry_in);
            ca = r_mid[CW-1:0];
        end else if (i_cmd.mul2) begin
            xa = XW'(i_dry_in);
            ca = $signed({1'b0, i_dry});
            xb = r_mid;
            cb = $signed({1'b0, i_wet});
        end else begin
            xa = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul1 || i_cmd.mul2) begin
            r_pa <= xa * ca;
            r_pb <= xb * cb;
        end
    end

    // round half up, then clamp to sample range
    always_comb begin
        sum   = SW'(r_pa) + SW'(r_pb);
        rnd_v = (sum + HALF) >>> 15;
        if (rnd_v > HI) begin
            sat_v = HI[S-1:0];
        end else if (rnd_v < LO) begin
            sat_v = LO[S-1:0];
        end else begin
            sat_v = rnd_v[S-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rnd1) begin
            if (i_mono) begin
                r_mid <= $signed(XW'(i_dry)) + XW'(rnd_v);
            end else begin
                r_mid <= XW'(sat_v);
            end
        end
        if (i_cmd.rnd2) begin
            r_res <= i_kill ? '0 : sat_v;
        end
    end

    assign o_res = r_res;

endmodule

// ===== design/bdgm_dpath.sv =====
module bdgm_dpath #(
    parameter int DELAY_DEPTH = 512,
    parameter int SAMPLE_BITS = 16,
    parameter int TDW         = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bdgm_pkg::t_cmd                    i_cmd,
    output bdgm_pkg::t_stat                   o_stat,
    input  logic [TDW-1:0]                    i_in_data,
    output logic [TDW-1:0]                    o_out_data,
    input  logic                              i_cfg_we,
    input  logic [bdgm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdgm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bdgm_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int AW = $clog2(DELAY_DEPTH);

    logic                r_stereo;
    logic [DELAY_W-1:0]  r_left_delay, r_right_delay;
    logic [GAIN_W-1:0]   r_left_gain, r_right_gain, r_wet, r_dist;

    logic signed [S-1:0] r_l, r_r, r_mono, r_out_l, r_out_r;
    logic signed [S:0]   sum_lr;
    logic signed [S-1:0] mono;
    logic [AW-1:0]       r_wp;
    logic                r_wrapped;
    logic [AW-1:0]       d_l, d_r, rp_l, rp_r;
    logic                r_hit_l, r_hit_r, r_vld_l, r_vld_r;
    logic signed [S-1:0] rd_l, rd_r, line_l, line_r, res_l, res_r;
    logic [GAIN_W-1:0]   gl, gr, wet, dry, dist_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo      <= 1'b1;
            r_left_delay  <= '0;
            r_right_delay <= '0;
            r_left_gain   <= UNITY;
            r_right_gain  <= UNITY;
            r_wet         <= UNITY;
            r_dist        <= UNITY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_STEREO_MODE:   r_stereo      <= i_cfg_data[0];
                CFG_LEFT_DELAY:    r_left_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_RIGHT_DELAY:   r_right_delay <= i_cfg_data[DELAY_W-1:0];
                CFG_LEFT_GAIN:     r_left_gain   <= i_cfg_data;
                CFG_RIGHT_GAIN:    r_right_gain  <= i_cfg_data;
                CFG_WET_MIX:       r_wet         <= i_cfg_data;
                CFG_DISTANCE_GAIN: r_dist        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_stat.stereo = r_stereo;

    assign gl     = (r_left_gain > UNITY) ? UNITY : r_left_gain;
    assign gr     = (r_right_gain > UNITY) ? UNITY : r_right_gain;
    assign wet    = (r_wet > UNITY) ? UNITY : r_wet;
    assign dist_g = (r_dist > UNITY) ? UNITY : r_dist;
    assign dry    = UNITY - wet;

    assign d_l = (32'(r_left_delay) > 32'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1)
                                                           : AW'(r_left_delay);
    assign d_r = (32'(r_right_delay) > 32'(DELAY_DEPTH - 1)) ? AW'(DELAY_DEPTH - 1)
                                                            : AW'(r_right_delay);

    assign rp_l = (r_wp >= d_l) ? r_wp - d_l
                                : AW'({1'b0, r_wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_l});
    assign rp_r = (r_wp >= d_r) ? r_wp - d_r
                                : AW'({1'b0, r_wp} + (AW+1)'(DELAY_DEPTH) - {1'b0, d_r});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_l <= i_in_data[S-1:0];
            r_r <= i_in_data[2*S-1:S];
        end
    end

    assign sum_lr = (S+1)'(r_l) + (S+1)'(r_r);
    assign mono   = sum_lr[S:1];

    // entries beyond the fill point read as zero until the line wraps once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_wrapped <= 1'b0;
        end else if (i_cmd.mem_step) begin
            if (32'(r_wp) == 32'(DELAY_DEPTH - 1)) begin
                r_wp      <= '0;
                r_wrapped <= 1'b1;
            end else begin
                r_wp <= r_wp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_step) begin
            r_mono  <= mono;
            r_hit_l <= (rp_l == r_wp);
            r_hit_r <= (rp_r == r_wp);
            r_vld_l <= r_wrapped || (rp_l <= r_wp);
            r_vld_r <= r_wrapped || (rp_r <= r_wp);
        end
    end

    bdgm_line #(.DEPTH(DELAY_DEPTH), .W(S)) u_left_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_step),
        .i_waddr (r_wp),
        .i_wdata (mono),
        .i_re    (i_cmd.mem_step),
        .i_raddr (rp_l),
        .o_rdata (rd_l)
    );

    bdgm_line #(.DEPTH(DELAY_DEPTH), .W(S)) u_right_line (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_step),
        .i_waddr (r_wp),
        .i_wdata (mono),
        .i_re    (i_cmd.mem_step),
        .i_raddr (rp_r),
        .o_rdata (rd_r)
    );

    assign line_l = r_hit_l ? r_mono : (r_vld_l ? rd_l : '0);
    assign line_r = r_hit_r ? r_mono : (r_vld_r ? rd_r : '0);

    bdgm_lane #(.SAMPLE_BITS(S)) u_left_lane (
        .i_clk    (i_clk),
        .i_cmd    (i_cmd),
        .i_mono   (!r_stereo),
        .i_kill   (1'b0),
        .i_dry_in (r_l),
        .i_line   (line_l),
        .i_gain   (gl),
        .i_dist   (dist_g),
        .i_dry    (dry),
        .i_wet    (wet),
        .o_res    (res_l)
    );

    bdgm_lane #(.SAMPLE_BITS(S)) u_right_lane (
        .i_clk    (i_clk),
        .i_cmd    (i_cmd),
        .i_mono   (!r_stereo),
        .i_kill   (!r_stereo),
        .i_dry_in (r_r),
        .i_line   (line_r),
        .i_gain   (gr),
        .i_dist   (dist_g),
        .i_dry    (dry),
        .i_wet    (wet),
        .o_res    (res_r)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_l <= res_l;
            r_out_r <= res_r;
        end
    end

    assign o_out_data = TDW'({r_out_r, r_out_l});

endmodule

// ===== design/bdgm_ctrl.sv =====
module bdgm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bdgm_pkg::t_stat i_stat,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bdgm_pkg::t_cmd  o_cmd
);
    import bdgm_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.stereo ? ST_READ : ST_MUL1;
                end
            end
            ST_READ: n_state = ST_MUL1;
            ST_MUL1: n_state = ST_RND1;
            ST_RND1: n_state = ST_MUL2;
            ST_MUL2: n_state = ST_RND2;
            ST_RND2: n_state = ST_HOLD;
            ST_HOLD: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_READ: o_cmd.mem_step = 1'b1;
            ST_MUL1: o_cmd.mul1     = 1'b1;
            ST_RND1: o_cmd.rnd1     = 1'b1;
            ST_MUL2: o_cmd.mul2     = 1'b1;
            ST_RND2: o_cmd.rnd2     = 1'b1;
            ST_HOLD: o_cmd.out_load = out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== design/binaural_delay_gain_mixer_core.sv =====
// Binaural delay and gain mixer. Each input beat is one stereo frame, each
// output beat one stereo result. In stereo mode the frame is averaged to mono,
// written into the left and right delay lines, read back at each ear's delay,
// scaled by the ear gain and blended with the dry channel by the wet share;
// in mono mode left is scaled by the dry share plus distance-weighted wet and
// right is zero. The sequencer passes each frame twice through the per-ear
// multiply and round stage, in stereo mode after the delay memory read. The
// output register lets a new frame start while the last result waits. Delay
// lines need no clearing pass after reset: unwritten entries read as zero
// until the write position first wraps. Configuration is written through the
// index port; the user must write it only while no frame is in flight, as the
// block itself does not enforce this.
module binaural_delay_gain_mixer_core #(
    parameter int DELAY_DEPTH = 512,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // left_sample, right_sample
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // left_out, right_out
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]        m_axis_tdata,
    input  logic                                      i_cfg_we,
    input  logic [bdgm_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [bdgm_pkg::CFG_DATA_W-1:0]           i_cfg_data
);
    import bdgm_pkg::*;

    localparam int TDW = ((2*SAMPLE_BITS+7)/8)*8;

    t_cmd  cmd;
    t_stat stat;

    bdgm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (stat),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    bdgm_dpath #(
        .DELAY_DEPTH (DELAY_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .TDW         (TDW)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

endmodule
